// ----- sv/shdiv_pkg.sv -----
// shared types and constants for the signed hardware divider
// no dependencies
`default_nettype none

package shdiv_pkg;

  typedef enum logic [1:0] {
    MODE_S32     = 2'd0,
    MODE_S64_S32 = 2'd1,
    MODE_S64     = 2'd2,
    MODE_RSVD    = 2'd3
  } mode_e;

  localparam int unsigned W = 64;

  localparam logic [W-1:0] Q0_NEG32 = 64'hFFFF_FFFF_0000_0001;
  localparam logic [W-1:0] Q0_POS32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [W-1:0] Q0_NEG64 = 64'h0000_0000_0000_0001;
  localparam logic [W-1:0] Q0_POS64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [W-1:0] numerator;
    logic [W-1:0] denominator;
  } in_t;

  typedef struct packed {
    logic [W-1:0] quotient;
    logic [W-1:0] remainder;
    logic         divide_by_zero;
  } out_t;

  // per-item side information carried down the pipeline
  typedef struct packed {
    logic         nneg;
    logic         qneg;
    logic         zero;
    logic         wide;
    logic         dz_flag;
    logic [W-1:0] nval;
  } side_t;

endpackage

`default_nettype wire

// ----- sv/signed_hardware_divider.sv -----
// signed 64/64 divider, fully pipelined: one transfer accepted every cycle
// operand prep is registered at the accepting edge, then come 64/BITS_PER_STAGE division
// stages (4 bits per stage by default) and one fix-up register that drives done_o
// throughput: one item per cycle, busy is always low, the quotient shift chain sets the depth
// reset clears valid bits and sets mode_q to MODE_S32 (s32/s32)
`default_nettype none

module signed_hardware_divider #(
  parameter int unsigned BITS_PER_STAGE = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire shdiv_pkg::in_t      in_i,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_wdata_i,
  output logic                     done_o,
  output shdiv_pkg::out_t          out_o
);

  localparam int unsigned NSTG = 64 / BITS_PER_STAGE;

  logic [1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= shdiv_pkg::MODE_S32;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  // operand prep: pick form, take magnitudes
  logic wide;
  logic [63:0] n, d, an, ad;
  shdiv_pkg::side_t side_d;

  always_comb begin
    wide = (mode_q == shdiv_pkg::MODE_S64_S32) || (mode_q == shdiv_pkg::MODE_S64);
    n = wide ? in_i.numerator
             : {{32{in_i.numerator[31]}}, in_i.numerator[31:0]};
    d = (mode_q == shdiv_pkg::MODE_S64) ? in_i.denominator
        : {{32{in_i.denominator[31]}}, in_i.denominator[31:0]};
    an = n[63] ? (64'd0 - n) : n;
    ad = d[63] ? (64'd0 - d) : d;
    side_d.nneg    = n[63];
    side_d.qneg    = n[63] ^ d[63];
    side_d.zero    = (d == 64'd0);
    side_d.wide    = wide;
    side_d.dz_flag = (in_i.denominator == 64'd0);
    side_d.nval    = n;
  end

  logic [NSTG:0]     v;
  logic [63:0]       rem [NSTG+1];
  logic [63:0]       quo [NSTG+1];
  logic [63:0]       dv  [NSTG+1];
  shdiv_pkg::side_t  sd  [NSTG+1];

  logic              v0_q;
  logic [63:0]       an_q, ad_q;
  shdiv_pkg::side_t  side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q   <= an;
    ad_q   <= ad;
    side_q <= side_d;
  end

  assign v[0]   = v0_q;
  assign rem[0] = '0;
  assign quo[0] = an_q;
  assign dv[0]  = ad_q;
  assign sd[0]  = side_q;

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    shdiv_stage #(.BITS(BITS_PER_STAGE)) u_stg (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v[g]),
      .rem_i  (rem[g]),
      .quo_i  (quo[g]),
      .div_i  (dv[g]),
      .side_i (sd[g]),
      .valid_o(v[g+1]),
      .rem_o  (rem[g+1]),
      .quo_o  (quo[g+1]),
      .div_o  (dv[g+1]),
      .side_o (sd[g+1])
    );
  end

  // sign fix-up and special cases
  shdiv_pkg::out_t res_d, res_q;
  logic            done_q;
  shdiv_pkg::side_t s;

  always_comb begin
    s = sd[NSTG];
    res_d.divide_by_zero = s.dz_flag;
    if (s.zero) begin
      res_d.remainder = s.nval;
      if (s.wide) begin
        res_d.quotient = s.nneg ? shdiv_pkg::Q0_NEG64 : shdiv_pkg::Q0_POS64;
      end else begin
        res_d.quotient = s.nneg ? shdiv_pkg::Q0_NEG32 : shdiv_pkg::Q0_POS32;
      end
    end else begin
      res_d.quotient  = s.qneg ? (64'd0 - quo[NSTG]) : quo[NSTG];
      res_d.remainder = s.nneg ? (64'd0 - rem[NSTG]) : rem[NSTG];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign out_o  = res_q;

`ifndef SYNTHESIS
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v[NSTG] |=> done_o) else $error("done lost");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v[NSTG] |=> !done_o) else $error("spurious done");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v[NSTG] && s.dz_flag) |-> s.zero) else $error("flag without zero divisor");
`endif

endmodule

`default_nettype wire

// ----- sv/shdiv_stage.sv -----
// one restoring-division stage, BITS quotient bits per register stage
// depends on shdiv_pkg
`default_nettype none

module shdiv_stage #(
  parameter int unsigned BITS = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire logic [63:0]           rem_i,
  input  wire logic [63:0]           quo_i,
  input  wire logic [63:0]           div_i,
  input  wire shdiv_pkg::side_t      side_i,
  output logic                       valid_o,
  output logic [63:0]                rem_o,
  output logic [63:0]                quo_o,
  output logic [63:0]                div_o,
  output shdiv_pkg::side_t           side_o
);

  logic [63:0] rem_d, quo_d;
  logic [64:0] trial;

  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    trial = '0;
    for (int i = 0; i < BITS; i++) begin
      // shift in next dividend bit, try subtract
      trial = {rem_d, quo_d[63]} - {1'b0, div_i};
      quo_d = {quo_d[62:0], ~trial[64]};
      rem_d = trial[64] ? {rem_d[62:0], quo_i[63-i]} : trial[63:0];
    end
  end

  logic valid_q;
  logic [63:0] rem_q, quo_q, div_q;
  shdiv_pkg::side_t side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    div_q  <= div_i;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire
